[design/drc_pkg.sv]
// Package for the dirty range coalescer: status codes, request codes,
// sequencer states and the compare bundle. No dependencies.
`default_nettype none
package drc_pkg;
   localparam logic [2:0] ST_RECORDED = 3'd0;
   localparam logic [2:0] ST_ZERO_LEN = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;
   localparam logic [2:0] ST_BAD_INST = 3'd5;

   localparam logic REQ_MARK  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT_WR,
      S_FLUSH_RD, S_FLUSH, S_OUT
   } state_type;

   // Outcome of comparing one stored range with the range being merged.
   typedef struct packed {
      logic below;    // new end lies before the stored start
      logic overlap;  // stored range overlaps or touches the new range
      logic [31:0] lo;
      logic [32:0] hi;
   } cmp_type;
endpackage
`default_nettype wire

[design/drc_cmp.sv]
// Shared compare unit for the dirty range coalescer: one stored range
// against the working range. Depends on drc_pkg.
`default_nettype none
module drc_cmp (
   input  wire logic [31:0] cur_s,
   input  wire logic [32:0] cur_e,
   input  wire logic [31:0] ent_s,
   input  wire logic [32:0] ent_e,
   output drc_pkg::cmp_type res
);
   always_comb begin
      res.below   = cur_e < {1'b0, ent_s};
      res.overlap = !res.below && (ent_e >= {1'b0, cur_s});
      res.lo      = (ent_s < cur_s) ? ent_s : cur_s;
      res.hi      = (ent_e > cur_e) ? ent_e : cur_e;
   end
endmodule
`default_nettype wire

[design/dirty_range_coalescer_top.sv]
// Top level of the dirty range coalescer: sequencer, range memory and
// output register. Depends on drc_pkg and drc_cmp.
`default_nettype none
// Keeps a sorted list of up to MAX_RANGES dirty byte ranges for each of
// INSTANCES buffers in one memory with a registered read port. A mark
// walks the instance's list one entry at a time, a read then a compare,
// through a shared compare unit, then shifts entries one at a time to
// insert or to compact absorbed ones. A flush emits one range at a time
// and reads the next only once rsp_tready has taken the last one.
// The block takes no new request until the previous result transaction is
// done. Bad instance, zero length and empty flush answer from S_IDLE.
module dirty_range_coalescer_top #(
   parameter int MAX_RANGES = 16,
   parameter int INSTANCES  = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: instance_req[1:0], range_offset[33:2], byte_count[65:34], zero fill
   input  wire logic [71:0] req_tdata,
   // tuser: req_type
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: status[2:0], range_start[34:3], range_length[67:35], zero fill
   output logic [71:0]      rsp_tdata,
   output logic             rsp_tlast
);
   localparam int IW = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
   localparam int PW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int AW = $clog2(INSTANCES * MAX_RANGES);
   localparam int DEPTH = INSTANCES * MAX_RANGES;

   drc_pkg::state_type state_ff, state_in;
   logic [2:0]  act_ff;
   logic [CW-1:0] cnt_ff [INSTANCES];
   logic [CW-1:0] cnt_in;
   logic cnt_we;
   logic [IW-1:0] inst_ff, inst_in;
   logic [31:0] s_ff, s_in;
   logic [32:0] e_ff, e_in;
   logic [CW-1:0] i_ff, i_in, n_ff, n_in, first_ff, first_in, nov_ff, nov_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic ins_ff, ins_in;
   logic [2:0]  o_st_ff, o_st_in;
   logic [31:0] o_s_ff, o_s_in;
   logic [32:0] o_l_ff, o_l_in;
   logic o_last_ff, o_last_in, o_v_ff, o_v_in;

   logic [31:0] mem_s [DEPTH];
   logic [32:0] mem_e [DEPTH];
   logic [31:0] rd_s;
   logic [32:0] rd_e;
   logic [PW-1:0] ra, wa;
   logic we;
   logic [31:0] wd_s;
   logic [32:0] wd_e;

   function automatic logic [AW-1:0] addr(input logic [IW-1:0] ins,
                                          input logic [PW-1:0] p);
      logic [AW-1:0] a;
      a = AW'(ins) * AW'(MAX_RANGES) + AW'(p);
      return a;
   endfunction

   always_ff @(posedge clock) begin
      if (we) begin
         mem_s[addr(inst_ff, wa)] <= wd_s;
         mem_e[addr(inst_ff, wa)] <= wd_e;
      end
      rd_s <= mem_s[addr(inst_ff, ra)];
      rd_e <= mem_e[addr(inst_ff, ra)];
   end

   drc_pkg::cmp_type c;
   drc_cmp u_cmp (.cur_s(s_ff), .cur_e(e_ff), .ent_s(rd_s), .ent_e(rd_e), .res(c));

   logic [IW-1:0] rq_inst;
   logic [1:0] rq_inst_raw;
   logic bad;
   logic [CW-1:0] drop;
   assign rq_inst_raw = req_tdata[1:0];
   assign rq_inst = IW'(rq_inst_raw);
   assign bad = ({1'b0, rq_inst_raw} >= act_ff) || (32'(rq_inst_raw) >= INSTANCES);
   assign req_tready = (state_ff == drc_pkg::S_IDLE) && !o_v_ff;
   assign drop = nov_ff - CW'(1);

   always_comb begin
      state_in = state_ff; inst_in = inst_ff; s_in = s_ff; e_in = e_ff;
      i_in = i_ff; n_in = n_ff; first_in = first_ff; nov_in = nov_ff;
      pos_in = pos_ff; ins_in = ins_ff;
      o_st_in = o_st_ff; o_s_in = o_s_ff; o_l_in = o_l_ff;
      o_last_in = o_last_ff; o_v_in = o_v_ff;
      cnt_in = '0; cnt_we = 1'b0;
      ra = i_ff[PW-1:0]; wa = i_ff[PW-1:0]; we = 1'b0; wd_s = rd_s; wd_e = rd_e;
      if (o_v_ff && rsp_tready) o_v_in = 1'b0;
      unique case (state_ff)
         drc_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               inst_in = bad ? '0 : rq_inst;
               s_in = req_tdata[33:2];
               e_in = {1'b0, req_tdata[33:2]} + {1'b0, req_tdata[65:34]};
               n_in = cnt_ff[bad ? '0 : rq_inst];
               i_in = '0; nov_in = '0; first_in = '0;
               pos_in = cnt_ff[bad ? '0 : rq_inst];
               o_s_in = '0; o_l_in = '0; o_last_in = 1'b1;
               if (bad) begin
                  o_st_in = drc_pkg::ST_BAD_INST; o_v_in = 1'b1;
               end else if (req_tuser == drc_pkg::REQ_FLUSH) begin
                  if (cnt_ff[rq_inst] == '0) begin
                     o_st_in = drc_pkg::ST_EMPTY; o_v_in = 1'b1;
                  end else state_in = drc_pkg::S_FLUSH_RD;
               end else if (req_tdata[65:34] == '0) begin
                  o_st_in = drc_pkg::ST_ZERO_LEN; o_v_in = 1'b1;
               end else state_in = drc_pkg::S_SCAN_RD;
            end
         end
         drc_pkg::S_SCAN_RD: begin
            if (i_ff >= n_ff) begin
               // Scan done: decide between insert, full and merge.
               o_st_in = drc_pkg::ST_RECORDED;
               if (nov_ff == '0) begin
                  if (n_ff == CW'(MAX_RANGES)) begin
                     o_st_in = drc_pkg::ST_FULL; o_v_in = 1'b1;
                     state_in = drc_pkg::S_IDLE;
                  end else begin
                     ins_in = 1'b1; i_in = n_ff; state_in = drc_pkg::S_SHIFT_RD;
                  end
               end else begin
                  we = 1'b1; wa = first_ff[PW-1:0]; wd_s = s_ff; wd_e = e_ff;
                  ins_in = 1'b0; i_in = first_ff + nov_ff;
                  state_in = drc_pkg::S_SHIFT_RD;
               end
            end else state_in = drc_pkg::S_SCAN;
         end
         drc_pkg::S_SCAN: begin
            if (c.below) begin
               pos_in = i_ff; i_in = n_ff;
            end else begin
               if (c.overlap) begin
                  if (nov_ff == '0) first_in = i_ff;
                  nov_in = nov_ff + CW'(1);
                  s_in = c.lo; e_in = c.hi;
               end
               i_in = i_ff + CW'(1);
            end
            state_in = drc_pkg::S_SCAN_RD;
         end
         drc_pkg::S_SHIFT_RD: begin
            if (ins_ff) begin
               if (i_ff == pos_ff) begin
                  we = 1'b1; wa = pos_ff[PW-1:0]; wd_s = s_ff; wd_e = e_ff;
                  cnt_we = 1'b1; cnt_in = n_ff + CW'(1);
                  o_v_in = 1'b1; state_in = drc_pkg::S_IDLE;
               end else begin
                  ra = PW'(i_ff - CW'(1)); state_in = drc_pkg::S_SHIFT_WR;
               end
            end else if (i_ff >= n_ff) begin
               cnt_we = 1'b1; cnt_in = n_ff - drop;
               o_v_in = 1'b1; state_in = drc_pkg::S_IDLE;
            end else state_in = drc_pkg::S_SHIFT_WR;
         end
         drc_pkg::S_SHIFT_WR: begin
            we = 1'b1;
            if (ins_ff) begin
               wa = i_ff[PW-1:0]; i_in = i_ff - CW'(1);
            end else begin
               wa = PW'(i_ff - drop); i_in = i_ff + CW'(1);
            end
            ra = i_in[PW-1:0];
            state_in = drc_pkg::S_SHIFT_RD;
         end
         drc_pkg::S_FLUSH_RD: state_in = drc_pkg::S_FLUSH;
         drc_pkg::S_FLUSH: begin
            if (!o_v_ff) begin
               o_st_in = drc_pkg::ST_RANGE; o_s_in = rd_s;
               o_l_in = rd_e - {1'b0, rd_s};
               o_last_in = (i_ff + CW'(1) == n_ff);
               o_v_in = 1'b1;
               state_in = drc_pkg::S_OUT;
            end
         end
         drc_pkg::S_OUT: begin
            if (!o_v_ff || rsp_tready) begin
               if (o_last_ff) begin
                  cnt_we = 1'b1; cnt_in = '0; state_in = drc_pkg::S_IDLE;
               end else begin
                  i_in = i_ff + CW'(1); ra = i_in[PW-1:0];
                  state_in = drc_pkg::S_FLUSH_RD;
               end
            end
         end
         default: state_in = drc_pkg::S_IDLE;
      endcase
      if (state_ff == drc_pkg::S_FLUSH_RD) ra = i_ff[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drc_pkg::S_IDLE; act_ff <= 3'd1; o_v_ff <= 1'b0;
         for (int k = 0; k < INSTANCES; k++) cnt_ff[k] <= '0;
      end else begin
         state_ff <= state_in; o_v_ff <= o_v_in;
         if (csr_we) act_ff <= csr_wdata;
         if (cnt_we) cnt_ff[inst_ff] <= cnt_in;
      end
      inst_ff <= inst_in; s_ff <= s_in; e_ff <= e_in; i_ff <= i_in; n_ff <= n_in;
      first_ff <= first_in; nov_ff <= nov_in; pos_ff <= pos_in; ins_ff <= ins_in;
      o_st_ff <= o_st_in; o_s_ff <= o_s_in; o_l_ff <= o_l_in; o_last_ff <= o_last_in;
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata = {4'd0, o_l_ff, o_s_ff, o_st_ff};
   assign rsp_tlast = o_last_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("request taken while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> cnt_in <= CW'(MAX_RANGES)) else $error("range count overflow");
endmodule
`default_nettype wire
